@@ rtl/core/mhic_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer hard-iron calibrator package
// Shared widths, constants and the word types of the input and result channels.
// ----------------------------------------------------------------------------
package mhic_pkg;

  localparam int unsigned AXIS_COUNT_DEF = 3;
  localparam int unsigned AXIS_MAX       = 3;

  localparam int unsigned RAW_W       = 16;
  localparam int unsigned OFFSET_W    = 23;
  localparam int unsigned SCALE_W     = 9;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned COUNT_W     = 32;

  // raw * 100 - offset needs 24 bits, times a 9-bit scale needs 34 bits signed.
  localparam int unsigned DIFF_W = 24;
  localparam int unsigned PROD_W = 34;
  localparam int unsigned MAG_W  = 32;

  localparam int RAW_TO_HUNDREDTHS = 100;

  // The two truncating divisions by 100 and by 300 equal one division by 30000.
  // It is done as a multiplication by ceil(2^46 / 30000) and a shift by 46,
  // which is exact for every magnitude below 2^31.
  localparam int unsigned      RECIP_PROD_W = 2 * MAG_W;
  localparam int unsigned      FIELD_SHIFT  = 46;
  localparam logic [MAG_W-1:0] FIELD_RECIP  = 32'd2345624806;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(100);

  localparam logic signed [RAW_W-1:0] RAW_MAX = 16'sh7FFF;
  localparam logic signed [RAW_W-1:0] RAW_MIN = 16'sh8000;

  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BASE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_BASE  = CFG_INDEX_W'(3);

  typedef struct packed {
    logic [1:0]              mode;
    logic                    read_ok;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [1:0]              cal_phase;
    logic                    sample_valid;
    logic signed [RAW_W-1:0] field_x;
    logic signed [RAW_W-1:0] field_y;
    logic signed [RAW_W-1:0] field_z;
    logic signed [RAW_W-1:0] cal_offset_x;
    logic signed [RAW_W-1:0] cal_offset_y;
    logic signed [RAW_W-1:0] cal_offset_z;
    logic [COUNT_W-1:0]      sample_count;
  } out_t;

endpackage
`default_nettype wire

@@ rtl/core/mhic_axis_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared axis correction unit
// Forms (raw*100 - offset)*scale and divides its magnitude by 30000 with a
// fixed reciprocal multiplication, truncating toward zero and keeping 16 bits.
// ----------------------------------------------------------------------------
module mhic_axis_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [mhic_pkg::RAW_W-1:0]   raw,
  input  logic signed [mhic_pkg::OFFSET_W-1:0] offset,
  input  logic        [mhic_pkg::SCALE_W-1:0] scale,
  output logic                                done,
  output logic signed [mhic_pkg::RAW_W-1:0]   field
);
  import mhic_pkg::*;

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_RECIP} ustate_t;

  ustate_t                  state_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic [SCALE_W-1:0]       scale_r;
  logic                     neg_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     done_r;
  logic signed [RAW_W-1:0]  field_r;

  logic signed [DIFF_W-1:0] diff_calc;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_mag;
  logic [RECIP_PROD_W-1:0]  recip_prod;
  logic [RAW_W-1:0]         quot;

  assign diff_calc  = (DIFF_W'(raw) * DIFF_W'(RAW_TO_HUNDREDTHS)) - DIFF_W'(offset);
  assign prod       = PROD_W'(diff_r) * PROD_W'($signed({1'b0, scale_r}));
  assign prod_mag   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign recip_prod = RECIP_PROD_W'(mag_r) * RECIP_PROD_W'(FIELD_RECIP);
  assign quot       = recip_prod[FIELD_SHIFT +: RAW_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        U_IDLE: begin
          if (start) begin
            diff_r  <= diff_calc;
            scale_r <= scale;
            state_r <= U_MUL;
          end
        end
        U_MUL: begin
          neg_r   <= prod[PROD_W-1];
          mag_r   <= prod_mag[MAG_W-1:0];
          state_r <= U_RECIP;
        end
        U_RECIP: begin
          field_r <= neg_r ? -quot : quot;
          done_r  <= 1'b1;
          state_r <= U_IDLE;
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign field = field_r;

endmodule
`default_nettype wire

@@ rtl/core/magnetometer_hard_iron_calibrator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer hard-iron calibrator
// Corrects three-axis samples and learns hard-iron offsets by min/max tracking.
// ----------------------------------------------------------------------------
// The input channel takes one word per event: a sample, a calibration start or
// a calibration stop. Every word gives exactly one result word on the output
// channel, carrying status and a snapshot of fields, offsets and sample count.
// Configuration words (offsets and scales) arrive on the cfg channel, which is
// always ready, and are meant to be written while the block is idle.
// A good sample runs each axis in turn through one shared multiply unit, and
// the result is registered after the last axis, with the next word taken in
// the following cycle. Other words go from acceptance straight to the emit
// state, from which the result is registered.
// One word is in progress at a time; in_ready is high only while idle.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished result and waits before taking the next word.
// Synchronous reset clears offsets, extremes, fields and count, sets the
// scales to one hundred and the calibration phase to idle.
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_calibrator #(
  parameter int unsigned AXIS_COUNT = mhic_pkg::AXIS_COUNT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  mhic_pkg::in_t                          in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output mhic_pkg::out_t                         out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mhic_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [mhic_pkg::OFFSET_W-1:0]          cfg_data
);
  import mhic_pkg::*;

  localparam int unsigned AXIS_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_EMIT} state_t;
  typedef enum logic [1:0] {
    PHASE_IDLE    = 2'd0,
    PHASE_RUNNING = 2'd1,
    PHASE_DONE    = 2'd2
  } phase_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_READ_ERR = 2'd1;
  localparam logic [1:0] STATUS_CAL_ERR  = 2'd2;
  localparam logic [1:0] MODE_SAMPLE     = 2'd0;
  localparam logic [1:0] MODE_START      = 2'd1;
  localparam logic [1:0] MODE_STOP       = 2'd2;

  typedef logic signed [RAW_W-1:0]    axis_val_t;
  typedef logic signed [OFFSET_W-1:0] offset_t;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [AXIS_W-1:0]   axis_r, axis_nxt;
  in_t                 in_r, in_nxt;
  logic                valid_r, valid_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_r, out_nxt;

  offset_t             off_r     [AXIS_COUNT];
  offset_t             off_nxt   [AXIS_COUNT];
  logic [SCALE_W-1:0]  scale_r   [AXIS_COUNT];
  logic [SCALE_W-1:0]  scale_nxt [AXIS_COUNT];
  axis_val_t           min_r     [AXIS_COUNT];
  axis_val_t           min_nxt   [AXIS_COUNT];
  axis_val_t           max_r     [AXIS_COUNT];
  axis_val_t           max_nxt   [AXIS_COUNT];
  axis_val_t           learn_r   [AXIS_COUNT];
  axis_val_t           learn_nxt [AXIS_COUNT];
  axis_val_t           field_r   [AXIS_COUNT];
  axis_val_t           field_nxt [AXIS_COUNT];

  axis_val_t           raw_a     [AXIS_COUNT];
  axis_val_t           mid       [AXIS_COUNT];
  offset_t             mid_hund  [AXIS_COUNT];
  logic                spread;

  logic [AXIS_MAX-1:0][RAW_W-1:0] raw3;
  logic [AXIS_MAX-1:0][RAW_W-1:0] field3;
  logic [AXIS_MAX-1:0][RAW_W-1:0] learn3;

  logic                accept;
  axis_val_t           raw_sel;
  logic                unit_done;
  axis_val_t           unit_field;

  assign raw3 = {in_r.raw_z, in_r.raw_y, in_r.raw_x};

  for (genvar g = 0; g < AXIS_MAX; g++) begin : g_axis
    if (g < AXIS_COUNT) begin : g_used
      assign raw_a[g]  = signed'(raw3[g]);
      assign field3[g] = field_r[g];
      assign learn3[g] = learn_r[g];
    end else begin : g_unused
      assign field3[g] = '0;
      assign learn3[g] = '0;
    end
  end

  assign accept  = in_valid && in_ready;
  assign raw_sel = raw_a[axis_r];

  always_comb begin
    logic signed [RAW_W:0] sum;
    logic signed [RAW_W:0] adj;
    spread = 1'b1;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      sum         = (RAW_W+1)'(min_r[i]) + (RAW_W+1)'(max_r[i]);
      adj         = sum + $signed({{RAW_W{1'b0}}, sum[RAW_W]});
      mid[i]      = adj[RAW_W:1];
      mid_hund[i] = OFFSET_W'(mid[i]) * OFFSET_W'(RAW_TO_HUNDREDTHS);
      if (min_r[i] >= max_r[i]) begin
        spread = 1'b0;
      end
    end
  end

  mhic_axis_unit u_axis_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_START),
    .raw    (raw_sel),
    .offset (off_r[axis_r]),
    .scale  (scale_r[axis_r]),
    .done   (unit_done),
    .field  (unit_field)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    status_nxt    = status_r;
    axis_nxt      = axis_r;
    in_nxt        = in_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    off_nxt       = off_r;
    scale_nxt     = scale_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    learn_nxt     = learn_r;
    field_nxt     = field_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        if (cfg_index == CFG_OFFSET_BASE + CFG_INDEX_W'(i)) begin
          off_nxt[i] = signed'(cfg_data);
        end
        if (cfg_index == CFG_SCALE_BASE + CFG_INDEX_W'(i)) begin
          scale_nxt[i] = cfg_data[SCALE_W-1:0];
        end
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          in_nxt     = in_data;
          status_nxt = STATUS_OK;
          axis_nxt   = '0;
          state_nxt  = S_EMIT;
          case (in_data.mode)
            MODE_SAMPLE: begin
              if (in_data.read_ok) begin
                state_nxt = S_START;
              end else begin
                valid_nxt  = 1'b0;
                status_nxt = STATUS_READ_ERR;
              end
            end
            MODE_START: begin
              for (int i = 0; i < AXIS_COUNT; i++) begin
                min_nxt[i] = RAW_MAX;
                max_nxt[i] = RAW_MIN;
              end
              phase_nxt = PHASE_RUNNING;
            end
            MODE_STOP: begin
              if (phase_r != PHASE_RUNNING) begin
                status_nxt = STATUS_CAL_ERR;
              end else if (!spread) begin
                phase_nxt  = PHASE_IDLE;
                status_nxt = STATUS_CAL_ERR;
              end else begin
                for (int i = 0; i < AXIS_COUNT; i++) begin
                  learn_nxt[i] = mid[i];
                  off_nxt[i]   = mid_hund[i];
                end
                phase_nxt = PHASE_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_START: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (unit_done) begin
          field_nxt[axis_r] = unit_field;
          if (phase_r == PHASE_RUNNING) begin
            if (raw_sel < min_r[axis_r]) begin
              min_nxt[axis_r] = raw_sel;
            end
            if (raw_sel > max_r[axis_r]) begin
              max_nxt[axis_r] = raw_sel;
            end
          end
          if (axis_r == AXIS_W'(AXIS_COUNT - 1)) begin
            valid_nxt = 1'b1;
            count_nxt = count_r + 1'b1;
            state_nxt = S_EMIT;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = S_START;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.status       = status_r;
          out_nxt.cal_phase    = phase_r;
          out_nxt.sample_valid = valid_r;
          out_nxt.field_x      = signed'(field3[0]);
          out_nxt.field_y      = signed'(field3[1]);
          out_nxt.field_z      = signed'(field3[2]);
          out_nxt.cal_offset_x = signed'(learn3[0]);
          out_nxt.cal_offset_y = signed'(learn3[1]);
          out_nxt.cal_offset_z = signed'(learn3[2]);
          out_nxt.sample_count = count_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PHASE_IDLE;
      status_r    <= STATUS_OK;
      axis_r      <= '0;
      valid_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        off_r[i]   <= '0;
        scale_r[i] <= SCALE_RESET;
        min_r[i]   <= '0;
        max_r[i]   <= '0;
        learn_r[i] <= '0;
        field_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      status_r    <= status_nxt;
      axis_r      <= axis_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      off_r       <= off_nxt;
      scale_r     <= scale_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      learn_r     <= learn_nxt;
      field_r     <= field_nxt;
    end
    in_r  <= in_nxt;
    out_r <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer hard-iron calibrator testbench
// Drives sample, calibration start and calibration stop words into the block,
// with random gaps on both channels. It predicts each result word from its own
// copy of the offsets, scales, extremes and counters, and checks every field.
// Register writes happen only once every pending result has arrived.
// ----------------------------------------------------------------------------
module tb_top;
  import mhic_pkg::*;

  localparam int unsigned AXIS_USED      = AXIS_COUNT_DEF;
  localparam int unsigned RESULT_LATENCY = 4 * AXIS_USED + 1;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int          FULL_SCALE_DIV = 300;
  localparam int          OFFSET_LO      = -3276800;
  localparam int          OFFSET_HI      = 3276700;
  localparam int          SCALE_HI       = 300;

  localparam logic [1:0] MODE_SAMPLE    = 2'd0;
  localparam logic [1:0] MODE_CAL_START = 2'd1;
  localparam logic [1:0] MODE_CAL_STOP  = 2'd2;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_READ_ERR = 2'd1;
  localparam logic [1:0] STATUS_CAL_ERR  = 2'd2;

  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_RUNNING = 2'd1;
  localparam logic [1:0] PHASE_DONE    = 2'd2;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_t                    in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_t                   out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [OFFSET_W-1:0]    cfg_data;

  // Predicted state of the block.
  logic signed [OFFSET_W-1:0] tb_offset   [AXIS_MAX];
  logic        [SCALE_W-1:0]  tb_scale    [AXIS_MAX];
  logic signed [RAW_W-1:0]    track_min   [AXIS_MAX];
  logic signed [RAW_W-1:0]    track_max   [AXIS_MAX];
  logic signed [RAW_W-1:0]    learned_mid [AXIS_MAX];
  logic signed [RAW_W-1:0]    field_hold  [AXIS_MAX];
  logic [1:0]                 phase_now;
  logic                       read_good;
  logic [COUNT_W-1:0]         good_count;

  out_t        awaited_snapshots[$];
  int unsigned events_sent;
  int unsigned fault_count;
  bit          pace_in;
  bit          pace_out;

  magnetometer_hard_iron_calibrator #(
    .AXIS_COUNT(AXIS_USED)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_t calibrate_event(in_t w);
    logic signed [RAW_W-1:0] raw [AXIS_MAX];
    out_t                    snap;
    logic [1:0]              st;
    bit                      spread;
    int                      mid;
    int                      a;
    longint                  diff;
    longint                  scaled;
    raw[0] = w.raw_x;
    raw[1] = w.raw_y;
    raw[2] = w.raw_z;
    st = STATUS_OK;
    case (w.mode)
      MODE_SAMPLE: begin
        if (!w.read_ok) begin
          read_good = 1'b0;
          st = STATUS_READ_ERR;
        end else begin
          for (a = 0; a < AXIS_USED; a++) begin
            diff = longint'(raw[a]) * RAW_TO_HUNDREDTHS - longint'(tb_offset[a]);
            scaled = diff * longint'(tb_scale[a]) / RAW_TO_HUNDREDTHS;
            field_hold[a] = RAW_W'(scaled / FULL_SCALE_DIV);
          end
          if (phase_now == PHASE_RUNNING) begin
            for (a = 0; a < AXIS_USED; a++) begin
              if (raw[a] < track_min[a]) track_min[a] = raw[a];
              if (raw[a] > track_max[a]) track_max[a] = raw[a];
            end
          end
          read_good = 1'b1;
          good_count = good_count + 1'b1;
        end
      end
      MODE_CAL_START: begin
        for (a = 0; a < AXIS_MAX; a++) begin
          track_min[a] = RAW_MAX;
          track_max[a] = RAW_MIN;
        end
        phase_now = PHASE_RUNNING;
      end
      MODE_CAL_STOP: begin
        if (phase_now != PHASE_RUNNING) begin
          st = STATUS_CAL_ERR;
        end else begin
          spread = 1'b1;
          for (a = 0; a < AXIS_USED; a++) begin
            if (track_min[a] >= track_max[a]) spread = 1'b0;
          end
          if (!spread) begin
            phase_now = PHASE_IDLE;
            st = STATUS_CAL_ERR;
          end else begin
            for (a = 0; a < AXIS_USED; a++) begin
              mid = (int'(track_min[a]) + int'(track_max[a])) / 2;
              learned_mid[a] = RAW_W'(mid);
              tb_offset[a] = OFFSET_W'(mid * RAW_TO_HUNDREDTHS);
            end
            phase_now = PHASE_DONE;
          end
        end
      end
      default: ;
    endcase
    snap.status       = st;
    snap.cal_phase    = phase_now;
    snap.sample_valid = read_good;
    snap.field_x      = field_hold[0];
    snap.field_y      = field_hold[1];
    snap.field_z      = field_hold[2];
    snap.cal_offset_x = learned_mid[0];
    snap.cal_offset_y = learned_mid[1];
    snap.cal_offset_z = learned_mid[2];
    snap.sample_count = good_count;
    return snap;
  endfunction

  function automatic logic signed [RAW_W-1:0] pick_raw(int centre, int span);
    int v;
    v = centre + int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return RAW_W'(v);
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  task automatic send_event(logic [1:0] mode, bit ok, logic signed [RAW_W-1:0] x,
                            logic signed [RAW_W-1:0] y, logic signed [RAW_W-1:0] z);
    int unsigned gap;
    in_t         w;
    w.mode    = mode;
    w.read_ok = ok;
    w.raw_x   = x;
    w.raw_y   = y;
    w.raw_z   = z;
    gap = pace_in ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (in_ready !== 1'b1);
    awaited_snapshots.push_back(calibrate_event(w));
    events_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_snapshots.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = OFFSET_W'(value);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx < CFG_SCALE_BASE) begin
      tb_offset[idx - CFG_OFFSET_BASE] = OFFSET_W'(value);
    end else begin
      tb_scale[idx - CFG_SCALE_BASE] = SCALE_W'(value);
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic randomise_registers();
    int k;
    int v;
    wait_drained();
    for (k = 0; k < AXIS_MAX; k++) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       v = OFFSET_LO;
          1:       v = OFFSET_HI;
          default: v = int'($urandom_range(0, OFFSET_HI - OFFSET_LO)) + OFFSET_LO;
        endcase
        write_register(CFG_INDEX_W'(CFG_OFFSET_BASE + k), v);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0:       v = 0;
          1:       v = SCALE_HI;
          default: v = int'($urandom_range(0, SCALE_HI));
        endcase
        write_register(CFG_INDEX_W'(CFG_SCALE_BASE + k), v);
      end
    end
  endtask

  task automatic test_directed_events();
    pace_in  = 1'b1;
    pace_out = 1'b1;
    send_event(MODE_SAMPLE, 1'b0, RAW_MAX, RAW_MIN, 16'sd0);
    send_event(MODE_UNUSED, 1'b1, RAW_MIN, RAW_MAX, -16'sd1);
    send_event(MODE_CAL_STOP, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    send_event(MODE_SAMPLE, 1'b1, RAW_MAX, RAW_MIN, 16'sd0);
    send_event(MODE_SAMPLE, 1'b1, -16'sd1, 16'sd1, 16'sd299);
    send_event(MODE_CAL_START, 1'b0, RAW_MIN, RAW_MIN, RAW_MIN);
    send_event(MODE_CAL_STOP, 1'b0, RAW_MAX, RAW_MAX, RAW_MAX);
    send_event(MODE_CAL_START, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    send_event(MODE_SAMPLE, 1'b1, 16'sd500, -16'sd500, 16'sd7);
    send_event(MODE_CAL_STOP, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    send_event(MODE_CAL_START, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    send_event(MODE_SAMPLE, 1'b1, 16'sd100, -16'sd5, RAW_MAX);
    send_event(MODE_SAMPLE, 1'b0, RAW_MIN, RAW_MAX, RAW_MIN);
    send_event(MODE_SAMPLE, 1'b1, -16'sd101, 16'sd2, RAW_MIN);
    send_event(MODE_UNUSED, 1'b0, RAW_MAX, RAW_MIN, RAW_MAX);
    send_event(MODE_CAL_STOP, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    send_event(MODE_SAMPLE, 1'b1, 16'sd1234, -16'sd4321, 16'sd0);
    send_event(MODE_CAL_STOP, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    send_event(MODE_CAL_START, 1'b0, 16'sd0, 16'sd0, 16'sd0);
    send_event(MODE_CAL_START, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    send_event(MODE_SAMPLE, 1'b1, 16'sd10, 16'sd20, 16'sd30);
    send_event(MODE_SAMPLE, 1'b1, 16'sd11, 16'sd25, 16'sd30);
    send_event(MODE_CAL_STOP, 1'b1, 16'sd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_register_extremes();
    wait_drained();
    write_register(CFG_INDEX_W'(CFG_OFFSET_BASE + 0), OFFSET_LO);
    write_register(CFG_INDEX_W'(CFG_OFFSET_BASE + 1), OFFSET_HI);
    write_register(CFG_INDEX_W'(CFG_OFFSET_BASE + 2), 0);
    write_register(CFG_INDEX_W'(CFG_SCALE_BASE + 0), SCALE_HI);
    write_register(CFG_INDEX_W'(CFG_SCALE_BASE + 1), 0);
    write_register(CFG_INDEX_W'(CFG_SCALE_BASE + 2), 1);
    send_event(MODE_SAMPLE, 1'b1, RAW_MAX, RAW_MIN, RAW_MAX);
    send_event(MODE_SAMPLE, 1'b1, RAW_MIN, RAW_MAX, RAW_MIN);
    wait_drained();
    write_register(CFG_INDEX_W'(CFG_OFFSET_BASE + 0), OFFSET_HI);
    write_register(CFG_INDEX_W'(CFG_OFFSET_BASE + 1), OFFSET_LO);
    write_register(CFG_INDEX_W'(CFG_OFFSET_BASE + 2), -1);
    write_register(CFG_INDEX_W'(CFG_SCALE_BASE + 1), SCALE_HI);
    write_register(CFG_INDEX_W'(CFG_SCALE_BASE + 2), SCALE_HI);
    send_event(MODE_SAMPLE, 1'b1, RAW_MIN, RAW_MAX, 16'sd0);
    send_event(MODE_SAMPLE, 1'b1, RAW_MAX, RAW_MIN, -16'sd1);
    wait_drained();
    for (int k = 0; k < AXIS_MAX; k++) begin
      write_register(CFG_INDEX_W'(CFG_OFFSET_BASE + k), 0);
      write_register(CFG_INDEX_W'(CFG_SCALE_BASE + k), int'(SCALE_RESET));
    end
  endtask

  task automatic test_drain_pause();
    pace_in  = 1'b0;
    pace_out = 1'b1;
    repeat (6) send_event(MODE_SAMPLE, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    wait_drained();
    repeat (6) send_event(MODE_SAMPLE, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    wait_drained();
  endtask

  task automatic test_random_traffic(int unsigned target, bit pin, bit pout);
    int unsigned stop_at;
    int unsigned n;
    int          centre [AXIS_MAX];
    int          span   [AXIS_MAX];
    int          k;
    pace_in  = pin;
    pace_out = pout;
    stop_at  = events_sent + target;
    while (events_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) randomise_registers();
      if ($urandom_range(0, 9) < 7) begin
        for (k = 0; k < AXIS_MAX; k++) begin
          centre[k] = int'($urandom_range(0, 40000)) - 20000;
          span[k]   = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 4000));
        end
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 30);
        send_event(MODE_CAL_START, 1'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
        repeat (n) begin
          case ($urandom_range(0, 29))
            0, 1, 2: send_event(MODE_SAMPLE, 1'b0, 16'($urandom), 16'($urandom),
                                16'($urandom));
            3:       send_event(MODE_UNUSED, 1'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom));
            4:       send_event(MODE_SAMPLE, 1'b1, 16'($urandom), 16'($urandom),
                                16'($urandom));
            5:       send_event(MODE_CAL_START, 1'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
            default: send_event(MODE_SAMPLE, 1'b1, pick_raw(centre[0], span[0]),
                                pick_raw(centre[1], span[1]),
                                pick_raw(centre[2], span[2]));
          endcase
        end
        send_event(MODE_CAL_STOP, 1'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
        if ($urandom_range(0, 5) == 0) begin
          send_event(MODE_CAL_STOP, 1'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_event(2'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        end
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin : result_monitor
    int unsigned stall;
    out_t        want;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = pace_out ? $urandom_range(0, 8) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (awaited_snapshots.size() == 0) begin
        $error("result word arrived with no snapshot pending");
        fault_count++;
      end else begin
        want = awaited_snapshots.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("cal_phase", want.cal_phase, out_data.cal_phase);
        check_field("sample_valid", want.sample_valid, out_data.sample_valid);
        check_field("field_x", $signed(want.field_x), $signed(out_data.field_x));
        check_field("field_y", $signed(want.field_y), $signed(out_data.field_y));
        check_field("field_z", $signed(want.field_z), $signed(out_data.field_z));
        check_field("cal_offset_x", $signed(want.cal_offset_x),
                    $signed(out_data.cal_offset_x));
        check_field("cal_offset_y", $signed(want.cal_offset_y),
                    $signed(out_data.cal_offset_y));
        check_field("cal_offset_z", $signed(want.cal_offset_z),
                    $signed(out_data.cal_offset_z));
        check_field("sample_count", want.sample_count, out_data.sample_count);
      end
    end
  end

  initial begin : stall_watch
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid & in_ready) === 1'b1 || (out_valid & out_ready) === 1'b1 ||
          (cfg_valid & cfg_ready) === 1'b1) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int k;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    pace_in     = 1'b1;
    pace_out    = 1'b1;
    events_sent = 0;
    fault_count = 0;
    for (k = 0; k < AXIS_MAX; k++) begin
      tb_offset[k]   = '0;
      tb_scale[k]    = SCALE_RESET;
      track_min[k]   = '0;
      track_max[k]   = '0;
      learned_mid[k] = '0;
      field_hold[k]  = '0;
    end
    phase_now  = PHASE_IDLE;
    read_good  = 1'b0;
    good_count = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed_events();
    test_register_extremes();
    test_drain_pause();
    test_random_traffic(500, 1'b1, 1'b1);
    test_random_traffic(300, 1'b0, 1'b0);
    test_random_traffic(250, 1'b1, 1'b0);
    test_random_traffic(150, 1'b0, 1'b1);

    wait_drained();
    repeat (2 * RESULT_LATENCY) @(posedge clk);
    if (awaited_snapshots.size() != 0) begin
      $error("%0d result words never arrived", awaited_snapshots.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mhic_pkg.sv
rtl/core/mhic_axis_unit.sv
rtl/core/magnetometer_hard_iron_calibrator.sv
verif/tb_top.sv
